/* rtl/core/clpv_pkg.sv */
// clpv_pkg: shared widths, register indexes, word types and fixed-point helpers
// for the cloth particle Verlet and constraint block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package clpv_pkg;

	localparam int POS_WIDTH   = 32;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_WIDTH  = 17;
	localparam int DT_WIDTH    = 22;
	localparam int MUL_B_WIDTH = DT_WIDTH;
	localparam int DIFF_WIDTH  = POS_WIDTH + 1;
	localparam int PROD_WIDTH  = DIFF_WIDTH + MUL_B_WIDTH + 1;
	localparam int SUM_WIDTH   = POS_WIDTH + 2;
	localparam int CFG_IDX_WIDTH = 3;

	localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

	localparam logic REQ_VERLET     = 1'b0;
	localparam logic REQ_CONSTRAINT = 1'b1;
	localparam logic KIND_VERLET     = 1'b0;
	localparam logic KIND_CONSTRAINT = 1'b1;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEEP_FACTOR = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_DT_SQUARED  = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACCEL_X     = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACCEL_Y     = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACCEL_Z     = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_DOUBLE_COEF = 3'd5;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_SINGLE_COEF = 3'd6;

	localparam logic [COEF_WIDTH-1:0] KEEP_FACTOR_RST = 17'd64881;
	localparam logic [DT_WIDTH-1:0]   DT_SQUARED_RST  = 22'd27689;
	localparam logic [COEF_WIDTH-1:0] DOUBLE_COEF_RST = 17'd32768;
	localparam logic [COEF_WIDTH-1:0] SINGLE_COEF_RST = 17'd65536;

	typedef struct packed {
		logic                        req_type;
		logic signed [POS_WIDTH-1:0] pos_x;
		logic signed [POS_WIDTH-1:0] pos_y;
		logic signed [POS_WIDTH-1:0] pos_z;
		logic signed [POS_WIDTH-1:0] old_x;
		logic signed [POS_WIDTH-1:0] old_y;
		logic signed [POS_WIDTH-1:0] old_z;
		logic                        movable;
		logic signed [POS_WIDTH-1:0] neighbour_y;
		logic                        neighbour_movable;
		logic                        first_neighbour;
		logic                        last_neighbour;
	} req_t;

	typedef struct packed {
		logic                        kind;
		logic signed [POS_WIDTH-1:0] new_x;
		logic signed [POS_WIDTH-1:0] new_y;
		logic signed [POS_WIDTH-1:0] new_z;
		logic signed [POS_WIDTH-1:0] prev_x;
		logic signed [POS_WIDTH-1:0] prev_y;
		logic signed [POS_WIDTH-1:0] prev_z;
	} rsp_t;

	typedef struct packed {
		logic        [COEF_WIDTH-1:0] keep_factor;
		logic        [DT_WIDTH-1:0]   dt_squared;
		logic signed [POS_WIDTH-1:0]  accel_x;
		logic signed [POS_WIDTH-1:0]  accel_y;
		logic signed [POS_WIDTH-1:0]  accel_z;
		logic        [COEF_WIDTH-1:0] double_move_coef;
		logic        [COEF_WIDTH-1:0] single_move_coef;
	} cfg_t;

	function automatic logic signed [POS_WIDTH-1:0] sat_prod(
		input logic signed [PROD_WIDTH-1:0] v
	);
		logic signed [POS_WIDTH-1:0] r;
		if (v[PROD_WIDTH-1:POS_WIDTH-1] == {(PROD_WIDTH-POS_WIDTH+1){v[PROD_WIDTH-1]}}) begin
			r = v[POS_WIDTH-1:0];
		end else if (v[PROD_WIDTH-1]) begin
			r = POS_MIN;
		end else begin
			r = POS_MAX;
		end
		return r;
	endfunction

	function automatic logic signed [POS_WIDTH-1:0] sat_sum(
		input logic signed [SUM_WIDTH-1:0] v
	);
		logic signed [POS_WIDTH-1:0] r;
		if (v[SUM_WIDTH-1:POS_WIDTH-1] == {(SUM_WIDTH-POS_WIDTH+1){v[SUM_WIDTH-1]}}) begin
			r = v[POS_WIDTH-1:0];
		end else if (v[SUM_WIDTH-1]) begin
			r = POS_MIN;
		end else begin
			r = POS_MAX;
		end
		return r;
	endfunction

	// floor(a * b / 2^FRAC_BITS), saturated to the position range
	function automatic logic signed [POS_WIDTH-1:0] mulq(
		input logic signed [DIFF_WIDTH-1:0] a,
		input logic        [MUL_B_WIDTH-1:0] b
	);
		logic signed [PROD_WIDTH-1:0] prod;
		logic signed [PROD_WIDTH-1:0] shifted;
		prod    = a * $signed({1'b0, b});
		shifted = prod >>> FRAC_BITS;
		return sat_prod(shifted);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/clpv_cfg_regs.sv */
// clpv_cfg_regs: configuration register file written through the cfg channel
// depends on clpv_pkg
`timescale 1ns / 1ps
`default_nettype none

module clpv_cfg_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [clpv_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  wire logic [clpv_pkg::POS_WIDTH-1:0]       cfg_data,
	output clpv_pkg::cfg_t                            cfg
);

	clpv_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keep_factor      <= clpv_pkg::KEEP_FACTOR_RST;
			cfg_q.dt_squared       <= clpv_pkg::DT_SQUARED_RST;
			cfg_q.accel_x          <= '0;
			cfg_q.accel_y          <= '0;
			cfg_q.accel_z          <= '0;
			cfg_q.double_move_coef <= clpv_pkg::DOUBLE_COEF_RST;
			cfg_q.single_move_coef <= clpv_pkg::SINGLE_COEF_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				clpv_pkg::CFG_KEEP_FACTOR: begin
					cfg_q.keep_factor <= cfg_data[clpv_pkg::COEF_WIDTH-1:0];
				end
				clpv_pkg::CFG_DT_SQUARED: begin
					cfg_q.dt_squared <= cfg_data[clpv_pkg::DT_WIDTH-1:0];
				end
				clpv_pkg::CFG_ACCEL_X: begin
					cfg_q.accel_x <= $signed(cfg_data);
				end
				clpv_pkg::CFG_ACCEL_Y: begin
					cfg_q.accel_y <= $signed(cfg_data);
				end
				clpv_pkg::CFG_ACCEL_Z: begin
					cfg_q.accel_z <= $signed(cfg_data);
				end
				clpv_pkg::CFG_DOUBLE_COEF: begin
					cfg_q.double_move_coef <= cfg_data[clpv_pkg::COEF_WIDTH-1:0];
				end
				clpv_pkg::CFG_SINGLE_COEF: begin
					cfg_q.single_move_coef <= cfg_data[clpv_pkg::COEF_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/clpv_verlet_axis.sv */
// clpv_verlet_axis: one axis of the Verlet position update, combinational
// depends on clpv_pkg
`timescale 1ns / 1ps
`default_nettype none

module clpv_verlet_axis (
	input  wire logic signed [clpv_pkg::POS_WIDTH-1:0]  pos,
	input  wire logic signed [clpv_pkg::POS_WIDTH-1:0]  old,
	input  wire logic signed [clpv_pkg::POS_WIDTH-1:0]  accel,
	input  wire logic        [clpv_pkg::COEF_WIDTH-1:0] keep_factor,
	input  wire logic        [clpv_pkg::DT_WIDTH-1:0]   dt_squared,
	output logic signed      [clpv_pkg::POS_WIDTH-1:0]  new_pos
);

	logic signed [clpv_pkg::DIFF_WIDTH-1:0]  vel_raw;
	logic signed [clpv_pkg::DIFF_WIDTH-1:0]  accel_ext;
	logic        [clpv_pkg::MUL_B_WIDTH-1:0] keep_ext;
	logic signed [clpv_pkg::POS_WIDTH-1:0]   vel;
	logic signed [clpv_pkg::POS_WIDTH-1:0]   grav;
	logic signed [clpv_pkg::SUM_WIDTH-1:0]   sum;

	assign vel_raw   = clpv_pkg::DIFF_WIDTH'(pos) - clpv_pkg::DIFF_WIDTH'(old);
	assign accel_ext = clpv_pkg::DIFF_WIDTH'(accel);
	assign keep_ext  = {{(clpv_pkg::MUL_B_WIDTH-clpv_pkg::COEF_WIDTH){1'b0}}, keep_factor};

	assign vel  = clpv_pkg::mulq(vel_raw, keep_ext);
	assign grav = clpv_pkg::mulq(accel_ext, dt_squared);

	assign sum = clpv_pkg::SUM_WIDTH'(pos) + clpv_pkg::SUM_WIDTH'(vel)
		+ clpv_pkg::SUM_WIDTH'(grav);

	assign new_pos = clpv_pkg::sat_sum(sum);

endmodule

`default_nettype wire

/* rtl/core/clpv_constraint.sv */
// clpv_constraint: running Y relaxation state and its per-neighbour update
// depends on clpv_pkg
`timescale 1ns / 1ps
`default_nettype none

module clpv_constraint (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire clpv_pkg::req_t                        word_s1,
	input  wire logic                                  step,
	input  wire logic        [clpv_pkg::COEF_WIDTH-1:0] double_move_coef,
	input  wire logic        [clpv_pkg::COEF_WIDTH-1:0] single_move_coef,
	output logic signed      [clpv_pkg::POS_WIDTH-1:0]  next_y
);

	logic signed [clpv_pkg::POS_WIDTH-1:0]   running_y_q;
	logic                                    self_movable_q;
	logic signed [clpv_pkg::POS_WIDTH-1:0]   base_y;
	logic                                    base_mov;
	logic        [clpv_pkg::COEF_WIDTH-1:0]  coef;
	logic signed [clpv_pkg::DIFF_WIDTH-1:0]  diff;
	logic signed [clpv_pkg::POS_WIDTH-1:0]   corr;
	logic signed [clpv_pkg::SUM_WIDTH-1:0]   sum;
	logic                                    upd;

	assign base_y   = word_s1.first_neighbour ? word_s1.pos_y : running_y_q;
	assign base_mov = word_s1.first_neighbour ? word_s1.movable : self_movable_q;
	assign coef     = word_s1.neighbour_movable ? double_move_coef : single_move_coef;

	assign diff = clpv_pkg::DIFF_WIDTH'(word_s1.neighbour_y) - clpv_pkg::DIFF_WIDTH'(base_y);
	assign corr = clpv_pkg::mulq(diff,
		{{(clpv_pkg::MUL_B_WIDTH-clpv_pkg::COEF_WIDTH){1'b0}}, coef});
	assign sum  = clpv_pkg::SUM_WIDTH'(base_y) + clpv_pkg::SUM_WIDTH'(corr);

	assign next_y = base_mov ? clpv_pkg::sat_sum(sum) : base_y;
	assign upd    = step && (word_s1.req_type == clpv_pkg::REQ_CONSTRAINT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_y_q    <= '0;
			self_movable_q <= 1'b0;
		end else if (upd) begin
			running_y_q    <= next_y;
			self_movable_q <= base_mov;
		end
	end

	// verlet words leave the relaxation state alone
	a_verlet_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		step && word_s1.req_type == clpv_pkg::REQ_VERLET
		|=> $stable(running_y_q) && $stable(self_movable_q))
		else $error("relaxation state changed by a verlet word");

	a_first_loads_flag: assert property (@(posedge clk) disable iff (!arst_n)
		upd && word_s1.first_neighbour |=> self_movable_q == $past(word_s1.movable))
		else $error("movable flag not taken on first neighbour");

	// fixed particle keeps its Y through the neighbour stream
	a_fixed_holds_y: assert property (@(posedge clk) disable iff (!arst_n)
		upd && !word_s1.first_neighbour && !self_movable_q |=> $stable(running_y_q))
		else $error("running y moved for a fixed particle");

endmodule

`default_nettype wire

/* rtl/core/cloth_particle_verlet_constraint.sv */
// cloth_particle_verlet_constraint: top level, input register, verlet lanes,
// constraint unit and result register; depends on clpv_pkg and all clpv_ modules
//
//  channel  signals                                   role
//  req      req_valid, req_ready, req (req_t)         particle word in
//  rsp      rsp_valid, rsp_ready, rsp (rsp_t)         result word out
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data register write, always ready
//
// one word per cycle sustained unless a held result stalls it; each word is held
// in the input register and its result is registered in the result register
// the running Y feedback closes through one multiply-add in the constraint unit
// reset clears both valid flags, the running Y state and loads the register defaults
// a held result stalls only words that produce a result; neighbour words without
// the last mark still drain while the result waits
`timescale 1ns / 1ps
`default_nettype none

module cloth_particle_verlet_constraint (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire clpv_pkg::req_t                     req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output clpv_pkg::rsp_t                          rsp,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [clpv_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  wire logic [clpv_pkg::POS_WIDTH-1:0]     cfg_data
);

	clpv_pkg::cfg_t cfg;
	clpv_pkg::req_t word_s1;
	logic           valid_s1;
	clpv_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	clpv_pkg::rsp_t result;
	logic           produces;
	logic           adv;

	logic signed [clpv_pkg::POS_WIDTH-1:0] vx;
	logic signed [clpv_pkg::POS_WIDTH-1:0] vy;
	logic signed [clpv_pkg::POS_WIDTH-1:0] vz;
	logic signed [clpv_pkg::POS_WIDTH-1:0] cy;

	clpv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clpv_verlet_axis u_axis_x (
		.pos         (word_s1.pos_x),
		.old         (word_s1.old_x),
		.accel       (cfg.accel_x),
		.keep_factor (cfg.keep_factor),
		.dt_squared  (cfg.dt_squared),
		.new_pos     (vx)
	);

	clpv_verlet_axis u_axis_y (
		.pos         (word_s1.pos_y),
		.old         (word_s1.old_y),
		.accel       (cfg.accel_y),
		.keep_factor (cfg.keep_factor),
		.dt_squared  (cfg.dt_squared),
		.new_pos     (vy)
	);

	clpv_verlet_axis u_axis_z (
		.pos         (word_s1.pos_z),
		.old         (word_s1.old_z),
		.accel       (cfg.accel_z),
		.keep_factor (cfg.keep_factor),
		.dt_squared  (cfg.dt_squared),
		.new_pos     (vz)
	);

	clpv_constraint u_cons (
		.clk              (clk),
		.arst_n           (arst_n),
		.word_s1          (word_s1),
		.step             (adv),
		.double_move_coef (cfg.double_move_coef),
		.single_move_coef (cfg.single_move_coef),
		.next_y           (cy)
	);

	assign produces  = (word_s1.req_type == clpv_pkg::REQ_VERLET) || word_s1.last_neighbour;
	assign adv       = valid_s1 && (!produces || !rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		result = '0;
		if (word_s1.req_type == clpv_pkg::REQ_VERLET) begin
			result.kind = clpv_pkg::KIND_VERLET;
			if (word_s1.movable) begin
				result.new_x  = vx;
				result.new_y  = vy;
				result.new_z  = vz;
				result.prev_x = word_s1.pos_x;
				result.prev_y = word_s1.pos_y;
				result.prev_z = word_s1.pos_z;
			end else begin
				result.new_x  = word_s1.pos_x;
				result.new_y  = word_s1.pos_y;
				result.new_z  = word_s1.pos_z;
				result.prev_x = word_s1.old_x;
				result.prev_y = word_s1.old_y;
				result.prev_z = word_s1.old_z;
			end
		end else begin
			result.kind  = clpv_pkg::KIND_CONSTRAINT;
			result.new_y = cy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && produces) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			word_s1 <= req;
		end
		if (adv && produces) begin
			rsp_q <= result;
		end
	end

	// neighbour word without last mark drains silently
	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv && word_s1.req_type == clpv_pkg::REQ_CONSTRAINT && !word_s1.last_neighbour
		&& (!rsp_valid_q || rsp_ready) |=> !rsp_valid_q)
		else $error("result raised by a non-final neighbour word");

	a_stall_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(word_s1))
		else $error("stalled input word lost or changed");

	a_constraint_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.kind == clpv_pkg::KIND_CONSTRAINT
		|-> rsp_q.new_x == '0 && rsp_q.new_z == '0 && rsp_q.prev_x == '0
		&& rsp_q.prev_y == '0 && rsp_q.prev_z == '0)
		else $error("unused constraint result fields not cleared");

endmodule

`default_nettype wire
